// ===== sv/ple_pkg.sv =====
// Shared types and constants for the positional list engine.
`default_nettype none
package ple_pkg;

  localparam int CAPACITY  = 16;
  localparam int WORD_BITS = 32;
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);

  localparam logic [2:0] REQ_INSERT    = 3'd0;
  localparam logic [2:0] REQ_REMOVE    = 3'd1;
  localparam logic [2:0] REQ_READ      = 3'd2;
  localparam logic [2:0] REQ_REPLACE   = 3'd3;
  localparam logic [2:0] REQ_WALK_FWD  = 3'd4;
  localparam logic [2:0] REQ_WALK_BACK = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OOB   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  position;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] word_out;
    logic [4:0]  entry_count;
    logic        last_of_run;
  } rsp_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE
  } cell_op_e;

  typedef struct packed {
    cell_op_e             op;
    logic [IDX_W-1:0]     pos;
    logic [WORD_BITS-1:0] data;
  } cell_cmd_t;

endpackage
`default_nettype wire

// ===== sv/ple_cell.sv =====
// One list slot: holds a word and shifts with its neighbors on edits.
`default_nettype none
module ple_cell
  import ple_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic [IDX_W-1:0]     idx_i,
  input  wire cell_cmd_t            cmd_i,
  input  wire logic [WORD_BITS-1:0] left_i,
  input  wire logic [WORD_BITS-1:0] right_i,
  output logic      [WORD_BITS-1:0] word_o
);

  logic [WORD_BITS-1:0] word_q, word_d;

  always_comb begin
    word_d = word_q;
    case (cmd_i.op)
      CELL_INSERT: begin
        if (idx_i > cmd_i.pos) begin
          word_d = left_i;
        end else if (idx_i == cmd_i.pos) begin
          word_d = cmd_i.data;
        end
      end
      CELL_REMOVE: begin
        if (idx_i >= cmd_i.pos) begin
          word_d = right_i;
        end
      end
      CELL_WRITE: begin
        if (idx_i == cmd_i.pos) begin
          word_d = cmd_i.data;
        end
      end
      default: word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule
`default_nettype wire

// ===== sv/positional_list_engine.sv =====
// Top level of the positional list engine: cell row, request decode, walk sequencer.
`default_nettype none
// An ordered list of up to CAPACITY words kept in a row of cells, one word per
// cell. Insert and remove shift every affected cell toward its neighbor in the
// same edge, so insert, remove, read, replace and error requests each produce
// one transfer with last_of_run set. A walk first enters the walk state and
// then emits one entry per cycle while the output side does not stall, in order
// through the single read port of the cell row; the input is stalled while a
// walk runs. A result waiting in the output register does not block the next
// request as long as the output side takes it in the same cycle. The word
// store has no reset: only entries below the current length are ever read
// back. Positions are checked against the length before anything changes, and
// a failed request leaves the list untouched.
module positional_list_engine
  import ple_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire req_t in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output rsp_t      out_data_o
);

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] len_q, len_d;
  logic [CNT_W-1:0] walk_cnt_q, walk_cnt_d;
  logic             walk_back_q, walk_back_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;

  logic                 out_free;
  logic                 in_acc;
  logic [7:0]           len_cmp;
  logic [IDX_W-1:0]     pos_idx;
  logic [IDX_W-1:0]     walk_idx;
  logic [IDX_W-1:0]     rd_idx;
  logic [WORD_BITS-1:0] rd_word;
  cell_cmd_t            cmd;
  logic [WORD_BITS-1:0] cell_word [CAPACITY];

  // Output register is free when empty or drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q == S_WALK) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign len_cmp  = 8'(len_q);
  assign pos_idx  = in_data_i.position[IDX_W-1:0];
  assign walk_idx = walk_back_q ? IDX_W'(len_q - walk_cnt_q - CNT_W'(1))
                                : IDX_W'(walk_cnt_q);
  assign rd_idx   = (state_q == S_WALK) ? walk_idx : pos_idx;
  assign rd_word  = cell_word[rd_idx];

  // Cell row: each cell sees its left and right neighbor.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [WORD_BITS-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_left
      assign left_w = cell_word[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_right
      assign right_w = cell_word[g+1];
    end
    ple_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .cmd_i   (cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (cell_word[g])
    );
  end

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    walk_cnt_d  = walk_cnt_q;
    walk_back_d = walk_back_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;

    cmd.op   = CELL_HOLD;
    cmd.pos  = pos_idx;
    cmd.data = WORD_BITS'(in_data_i.payload);

    if (state_q == S_WALK) begin
      if (out_free) begin
        out_valid_d          = 1'b1;
        out_d.status         = ST_OK;
        out_d.word_out       = 32'(rd_word);
        out_d.entry_count    = 5'(len_q);
        out_d.last_of_run    = (walk_cnt_q + CNT_W'(1)) == len_q;
        walk_cnt_d           = walk_cnt_q + CNT_W'(1);
        if (out_d.last_of_run) begin
          state_d = S_IDLE;
        end
      end
    end else if (in_acc) begin
      out_valid_d       = 1'b1;
      out_d.status      = ST_OK;
      out_d.word_out    = '0;
      out_d.last_of_run = 1'b1;
      case (in_data_i.req_type)
        REQ_INSERT: begin
          if (in_data_i.position > len_cmp) begin
            out_d.status = ST_OOB;
          end else if (len_q == CNT_W'(CAPACITY)) begin
            out_d.status = ST_FULL;
          end else begin
            cmd.op = CELL_INSERT;
            len_d  = len_q + CNT_W'(1);
          end
        end
        REQ_REMOVE, REQ_READ, REQ_REPLACE: begin
          if (len_q == '0) begin
            out_d.status = ST_EMPTY;
          end else if (in_data_i.position >= len_cmp) begin
            out_d.status = ST_OOB;
          end else begin
            case (in_data_i.req_type)
              REQ_REMOVE: begin
                cmd.op = CELL_REMOVE;
                len_d  = len_q - CNT_W'(1);
              end
              REQ_READ:    out_d.word_out = 32'(rd_word);
              default:     cmd.op = CELL_WRITE;
            endcase
          end
        end
        REQ_WALK_FWD, REQ_WALK_BACK: begin
          if (len_q == '0) begin
            out_d.status = ST_EMPTY;
          end else begin
            // Results come from the walk state, one entry per cycle while the output is not stalled.
            out_valid_d = 1'b0;
            state_d     = S_WALK;
            walk_cnt_d  = '0;
            walk_back_d = in_data_i.req_type == REQ_WALK_BACK;
          end
        end
        default: out_d.status = ST_OK;
      endcase
      out_d.entry_count = 5'(len_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      walk_cnt_q  <= '0;
      walk_back_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      walk_cnt_q  <= walk_cnt_d;
      walk_back_q <= walk_back_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== sv/ple_checker.sv =====
// Port-level checks for the positional list engine, bound to the top level.
`default_nettype none
module ple_port_checker
  import ple_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire req_t in_data_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire rsp_t out_data_o
);

  // A stalled result transfer holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Mid-walk results are ok, and the input is held while a walk runs.
  a_walk_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> out_data_o.status == ST_OK)
    else $error("non-final result with error status");

  a_walk_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> in_stall_o)
    else $error("input taken during a walk");

  // Empty status only with an empty list.
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |-> out_data_o.entry_count == '0)
    else $error("empty status with entries present");

endmodule

bind positional_list_engine ple_port_checker u_ple_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire
